@@ design/csavg_pkg.sv @@
// Shared widths, reset values and register codes for the calibrated sample averager.
// No dependencies; used by calibrated_sample_averager and csavg_checker.
package csavg_pkg;

  // Payload and datapath widths
  localparam int RAW_W  = 12;  // converter reading
  localparam int GAIN_W = 16;  // signed gain, 2^15 = unity
  localparam int OFFS_W = 16;  // signed offset
  localparam int AVG_W  = 16;  // result
  localparam int PROD_W = 29;  // 13b signed sample times 16b gain
  localparam int TRNC_W = 14;  // product / 2^15
  localparam int CAL_W  = 17;  // truncated product plus offset
  localparam int SUM_W  = 24;  // running sum
  localparam int CNT_W  = 7;   // samples in current block
  localparam int FRAC_W = 15;  // gain fraction bits

  // APB port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register select (paddr bit 2)
  localparam logic REG_GAIN   = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  localparam logic signed [GAIN_W-1:0] GAIN_RESET   = 16'sh7FFF;
  localparam logic signed [OFFS_W-1:0] OFFSET_RESET = 16'sh0000;

endpackage

@@ design/calibrated_sample_averager.sv @@
// Calibrated sample averager: gain/offset correction of 12-bit samples, block mean.
// Depends on csavg_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one converter sample per beat,
//   with a restart flag that drops the partial block and opens a new one with
//   this sample. Output channel (out_valid_o / out_stall_i) carries one average
//   per completed block of BLOCK_SAMPLES samples: the calibrated mean, rounded
//   half up, clamped to 0..65535.
//   Each sample is scaled as trunc(raw * gain / 2^15) + offset; gain and offset
//   are written over the APB port (gain at 0x0, offset at 0x4) while idle.
// Timing:
//   Seven-stage pipeline, one beat per cycle sustained while out_stall_i is low.
//   A closing beat passes S1..S3; its total, dividend, quotient and average fill
//   S4..S7, and S7 drives out_valid_o. The stages are set by the two multipliers
//   (sample x gain, sum x reciprocal of N), each followed by a register.
// Reset: clears the pipeline valids, the running sum and sample count, and
//   loads gain = 32767, offset = 0.
// Stall: a stalled result holds in the output register; upper stages keep
//   accepting until every stage is full, only then in_stall_o goes high.
module calibrated_sample_averager #(
  parameter int BLOCK_SAMPLES = 10  // 1..64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // APB configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [csavg_pkg::APB_AW-1:0]      paddr,
  input  logic [csavg_pkg::APB_DW-1:0]      pwdata,
  output logic [csavg_pkg::APB_DW-1:0]      prdata,
  output logic                              pready,
  // Sample input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [csavg_pkg::RAW_W-1:0]       raw_sample_i,
  input  logic                              restart_i,
  // Average output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [csavg_pkg::AVG_W-1:0]       average_o
);

  // Block length, forced to at least one
  localparam int N     = (BLOCK_SAMPLES < 1) ? 1 : BLOCK_SAMPLES;
  // Exact floor division for dividends below 2^24 and N up to 128:
  // q = (d * ceil(2^31 / N)) >> 31
  localparam int SHIFT = 31;
  localparam int RCP_W = 32;
  localparam int DIVP_W = csavg_pkg::SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << SHIFT) + 64'(N) - 64'd1) / 64'(N));
  localparam logic [csavg_pkg::SUM_W-1:0] HALF_N = csavg_pkg::SUM_W'(N / 2);
  localparam logic [csavg_pkg::CNT_W-1:0] N_CNT  = csavg_pkg::CNT_W'(N);
  localparam int QUOT_W = csavg_pkg::SUM_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [csavg_pkg::GAIN_W-1:0] gain_q;
  logic signed [csavg_pkg::OFFS_W-1:0] offset_q;
  logic                                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= csavg_pkg::GAIN_RESET;
      offset_q <= csavg_pkg::OFFSET_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        csavg_pkg::REG_GAIN:   gain_q   <= pwdata[csavg_pkg::GAIN_W-1:0];
        csavg_pkg::REG_OFFSET: offset_q <= pwdata[csavg_pkg::OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      csavg_pkg::REG_GAIN:
        prdata = csavg_pkg::APB_DW'({1'b0, gain_q});
      csavg_pkg::REG_OFFSET:
        prdata = csavg_pkg::APB_DW'({1'b0, offset_q});
      default:
        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when empty or when it drains
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic ld1, ld2, ld3, ld4, ld5, ld6, ld7;

  assign ld7 = !v7_q || !out_stall_i;
  assign ld6 = !v6_q || ld7;
  assign ld5 = !v5_q || ld6;
  assign ld4 = !v4_q || ld5;
  assign ld3 = !v3_q || ld4;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;

  assign in_stall_o = !ld1;

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  // S1: input register
  logic [csavg_pkg::RAW_W-1:0]         raw1_q;
  logic                                rst1_q;
  // S2: sample x gain
  logic signed [csavg_pkg::PROD_W-1:0] prod_d, prod2_q;
  logic                                rst2_q;
  // S3: truncate toward zero, add offset
  logic signed [csavg_pkg::TRNC_W-1:0] trunc_d;
  logic signed [csavg_pkg::CAL_W-1:0]  cal_d, cal3_q;
  logic                                rst3_q;
  // Accumulator
  logic signed [csavg_pkg::SUM_W-1:0]  sum_q, sum_base, sum_d;
  logic [csavg_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic                                blk_done;
  logic                                acc_fire;
  // S4: block total
  logic signed [csavg_pkg::SUM_W-1:0]  total4_q;
  // S5: dividend with half-N bias for round half up
  logic [csavg_pkg::SUM_W-1:0]         div5_q;
  logic                                neg5_q;
  // S6: quotient
  logic [DIVP_W-1:0]                   divp_d;
  logic [QUOT_W-1:0]                   quot6_q;
  logic                                neg6_q;
  // S7: output register
  logic [csavg_pkg::AVG_W-1:0]         avg_d, avg7_q;

  assign prod_d = csavg_pkg::PROD_W'($signed({1'b0, raw1_q}))
                * csavg_pkg::PROD_W'(gain_q);

  // Floor of product / 2^15, bumped by one for negative inexact values
  assign trunc_d = prod2_q[csavg_pkg::PROD_W-1:csavg_pkg::FRAC_W]
                 + csavg_pkg::TRNC_W'(prod2_q[csavg_pkg::PROD_W-1]
                                      && (|prod2_q[csavg_pkg::FRAC_W-1:0]));
  assign cal_d   = csavg_pkg::CAL_W'(trunc_d) + csavg_pkg::CAL_W'(offset_q);

  assign sum_base = rst3_q ? '0 : sum_q;
  assign sum_d    = sum_base + csavg_pkg::SUM_W'(cal3_q);
  assign cnt_d    = (rst3_q ? '0 : cnt_q) + csavg_pkg::CNT_W'(1);
  assign blk_done = cnt_d >= N_CNT;
  assign acc_fire = v3_q && ld4;

  assign divp_d = DIVP_W'(div5_q) * DIVP_W'(RECIP);

  always_comb begin
    if (neg6_q) begin
      avg_d = '0;
    end else if (|quot6_q[QUOT_W-1:csavg_pkg::AVG_W]) begin
      avg_d = '1;
    end else begin
      avg_d = quot6_q[csavg_pkg::AVG_W-1:0];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      if (ld1) v1_q <= in_valid_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
      if (ld4) v4_q <= v3_q && blk_done;
      if (ld5) v5_q <= v4_q;
      if (ld6) v6_q <= v5_q;
      if (ld7) v7_q <= v6_q;
      if (acc_fire) begin
        if (blk_done) begin
          sum_q <= '0;
          cnt_q <= '0;
        end else begin
          sum_q <= sum_d;
          cnt_q <= cnt_d;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ld1) begin
      raw1_q <= raw_sample_i;
      rst1_q <= restart_i;
    end
    if (ld2) begin
      prod2_q <= prod_d;
      rst2_q  <= rst1_q;
    end
    if (ld3) begin
      cal3_q <= cal_d;
      rst3_q <= rst2_q;
    end
    if (ld4) begin
      total4_q <= sum_d;
    end
    if (ld5) begin
      neg5_q <= total4_q[csavg_pkg::SUM_W-1];
      div5_q <= {1'b0, total4_q[csavg_pkg::SUM_W-2:0]} + HALF_N;
    end
    if (ld6) begin
      neg6_q  <= neg5_q;
      quot6_q <= divp_d[SHIFT +: QUOT_W];
    end
    if (ld7) begin
      avg7_q <= avg_d;
    end
  end

  assign out_valid_o = v7_q;
  assign average_o   = avg7_q;

endmodule

@@ design/csavg_checker.sv @@
// Port-level checks for calibrated_sample_averager, attached by bind.
// Depends on csavg_pkg.
module csavg_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [csavg_pkg::APB_AW-1:0]  paddr,
  input logic [csavg_pkg::APB_DW-1:0]  pwdata,
  input logic [csavg_pkg::APB_DW-1:0]  prdata,
  input logic                          pready,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [csavg_pkg::RAW_W-1:0]   raw_sample_i,
  input logic                          restart_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [csavg_pkg::AVG_W-1:0]   average_o
);

  logic gain_wr;
  assign gain_wr = psel && penable && pwrite && pready && (paddr[2] == csavg_pkg::REG_GAIN);

  // Stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(average_o))
    else $error("stalled output beat changed");

  // Stalled input beat stays put
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(raw_sample_i) && $stable(restart_i))
    else $error("stalled input beat changed");

  // Input only backs up when the output side is full and stalled
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output free");

  // Gain readback matches last write
  a_gain_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_wr ##1 (psel && !pwrite && (paddr[2] == csavg_pkg::REG_GAIN))
      |-> prdata[csavg_pkg::GAIN_W-1:0] == $past(pwdata[csavg_pkg::GAIN_W-1:0]))
    else $error("gain readback mismatch");

  // Register reads are zero above the 16-bit fields
  a_rd_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && !pwrite |-> prdata[csavg_pkg::APB_DW-1:csavg_pkg::GAIN_W] == '0)
    else $error("nonzero upper read data");

endmodule

bind calibrated_sample_averager csavg_checker u_csavg_checker (.*);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for calibrated_sample_averager: directed table, then random beats.
// Depends on csavg_pkg and the averager RTL; predicts block averages on its own model.
module testbench;

  localparam int BLOCK_N   = 10;         // must match the DUT parameter
  localparam int DRAIN_CYC = 16;         // covers 7-stage pipeline plus margin
  localparam int RAND_BEATS = 1250;

  // Directed table row kinds
  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_GAIN,
    ROW_OFFSET
  } row_kind_e;

  typedef struct packed {
    row_kind_e                    kind;
    logic [15:0]                  value;     // register value for ROW_GAIN / ROW_OFFSET
    logic [csavg_pkg::RAW_W-1:0]  raw;
    logic                         restart;   // applied to the first beat of the row only
    logic [7:0]                   reps;
    logic                         typed;     // avg below is the known answer for this block
    logic [csavg_pkg::AVG_W-1:0]  avg;
  } dir_row_t;

  localparam int DIR_ROWS = 8;
  localparam dir_row_t DIR_TBL [0:DIR_ROWS-1] = '{
    // reset gain 32767: raw 4095 calibrates to 4094; partial block is dropped by restart
    '{ROW_SAMPLE, 16'h0000, 12'hFFF, 1'b0, 8'd2,  1'b0, 16'd0},
    '{ROW_SAMPLE, 16'h0000, 12'hFFF, 1'b1, 8'd10, 1'b1, 16'd4094},
    // most negative gain and offset: mean below zero clamps to 0, restart on a boundary
    '{ROW_GAIN,   16'h8000, 12'h000, 1'b0, 8'd0,  1'b0, 16'd0},
    '{ROW_OFFSET, 16'h8000, 12'h000, 1'b0, 8'd0,  1'b0, 16'd0},
    '{ROW_SAMPLE, 16'h0000, 12'hFFF, 1'b1, 8'd10, 1'b1, 16'd0},
    // largest gain and offset; last beat of the block makes the mean round up
    '{ROW_GAIN,   16'h7FFF, 12'h000, 1'b0, 8'd0,  1'b0, 16'd0},
    '{ROW_OFFSET, 16'h7FFF, 12'h000, 1'b0, 8'd0,  1'b0, 16'd0},
    '{ROW_SAMPLE, 16'h0000, 12'hFFF, 1'b0, 8'd9,  1'b0, 16'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [csavg_pkg::APB_AW-1:0]   paddr = '0;
  logic [csavg_pkg::APB_DW-1:0]   pwdata = '0;
  logic [csavg_pkg::APB_DW-1:0]   prdata;
  logic                           pready;

  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [csavg_pkg::RAW_W-1:0]    raw_sample_i = '0;
  logic                           restart_i = 1'b0;

  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [csavg_pkg::AVG_W-1:0]    average_o;

  calibrated_sample_averager #(
    .BLOCK_SAMPLES(BLOCK_N)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .raw_sample_i (raw_sample_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .average_o    (average_o)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: its own copy of the registers and the block accumulator
  logic signed [csavg_pkg::GAIN_W-1:0] gain_q = csavg_pkg::GAIN_RESET;
  logic signed [csavg_pkg::OFFS_W-1:0] offs_q = csavg_pkg::OFFSET_RESET;
  int                       block_sum = 0;
  int                       block_cnt = 0;

  logic [csavg_pkg::AVG_W-1:0] avg_expected_q[$];
  int               mismatch_cnt = 0;
  int               beats_sent = 0;
  int               burst_left = 0;
  int unsigned      rx_cyc = 0;
  logic [csavg_pkg::AVG_W-1:0] avg_want;

  // Calibrate one sample, fold it into the block; flags and returns the average on
  // the beat that closes the block. SV int division truncates toward zero as needed.
  function automatic void accumulate_sample(input logic [csavg_pkg::RAW_W-1:0] raw,
                                            input logic rst, output bit done,
                                            output logic [csavg_pkg::AVG_W-1:0] avg);
    int cal;
    int quo;
    int rem;
    cal = (int'(raw) * int'(gain_q)) / 32768 + int'(offs_q);
    if (rst) begin
      block_sum = 0;
      block_cnt = 0;
    end
    block_sum += cal;
    block_cnt++;
    done = 1'b0;
    avg  = '0;
    if (block_cnt >= BLOCK_N) begin
      done = 1'b1;
      if (block_sum >= 0) begin
        quo = block_sum / BLOCK_N;
        rem = block_sum % BLOCK_N;
        if (2 * rem >= BLOCK_N) quo++;   // round half up
        if (quo > 65535) quo = 65535;
        avg = quo[csavg_pkg::AVG_W-1:0];
      end
      block_sum = 0;
      block_cnt = 0;
    end
  endfunction

  // Present one sample beat. Sender works in bursts; between bursts valid may drop for a
  // random gap. Valid is left high after acceptance so back-to-back beats need no toggle.
  task automatic send_sample(input logic [csavg_pkg::RAW_W-1:0] raw, input logic rst,
                             input logic typed, input logic [csavg_pkg::AVG_W-1:0] typed_avg);
    int gap;
    bit done;
    logic [csavg_pkg::AVG_W-1:0] avg;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    raw_sample_i <= raw;
    restart_i    <= rst;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    accumulate_sample(raw, rst, done, avg);
    if (done) avg_expected_q.push_back(typed ? typed_avg : avg);
  endtask

  // Block goes idle: no beat offered, every average collected, pipeline flushed of
  // beats that close no block.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (avg_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  // APB write (setup + access), then read back and compare the low half-word.
  task automatic write_reg(input logic reg_sel, input logic [15:0] value);
    logic [csavg_pkg::APB_DW-1:0] junk;
    junk = $urandom();
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {junk[31:16], value};   // upper bits are don't-care
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_sel == csavg_pkg::REG_GAIN) gain_q = value;
    else offs_q = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== value) begin
      $error("%s: expected %0d, got %0d",
             (reg_sel == csavg_pkg::REG_GAIN) ? "gain_factor" : "offset_value",
             $signed(value), $signed(prdata[15:0]));
      mismatch_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'h4000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_offset();
    int v;
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($urandom());
      default: begin
        v = int'($urandom_range(0, 4000)) - 2000;   // keep many means inside the range
        return v[15:0];
      end
    endcase
  endfunction

  // Receiver: checks each accepted average against the oldest expectation and
  // stalls on a pattern that cycles through quiet, light, heavy and periodic modes.
  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (avg_expected_q.size() == 0) begin
        $error("average: no beat expected, got %0d", average_o);
        mismatch_cnt++;
      end else begin
        avg_want = avg_expected_q.pop_front();
        if (average_o !== avg_want) begin
          $error("average: expected %0d, got %0d", avg_want, average_o);
          mismatch_cnt++;
        end
      end
    end
    case ((rx_cyc / 256) % 4)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ((rx_cyc % 7) < 3);
    endcase
  end

  initial begin
    int phase_len;
    logic [csavg_pkg::RAW_W-1:0] raw;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    for (int i = 0; i < DIR_ROWS; i++) begin
      case (DIR_TBL[i].kind)
        ROW_GAIN: begin
          write_reg(csavg_pkg::REG_GAIN, DIR_TBL[i].value);
        end
        ROW_OFFSET: begin
          write_reg(csavg_pkg::REG_OFFSET, DIR_TBL[i].value);
        end
        default: begin
          for (int k = 0; k < DIR_TBL[i].reps; k++)
            send_sample(DIR_TBL[i].raw, DIR_TBL[i].restart && (k == 0),
                        DIR_TBL[i].typed, DIR_TBL[i].avg);
        end
      endcase
    end
    send_sample(12'h000, 1'b0, 1'b0, '0);   // closes the rounding block

    // Random part: settings change between phases, each write waits for idle
    while (beats_sent < RAND_BEATS) begin
      if ($urandom_range(0, 3) != 0) write_reg(csavg_pkg::REG_GAIN, pick_gain());
      if ($urandom_range(0, 3) != 0) write_reg(csavg_pkg::REG_OFFSET, pick_offset());
      phase_len = $urandom_range(40, 160);
      for (int k = 0; k < phase_len; k++) begin
        case ($urandom_range(0, 7))
          0: raw = '0;
          1: raw = '1;
          default: raw = csavg_pkg::RAW_W'($urandom());
        endcase
        send_sample(raw, ($urandom_range(0, 15) == 0), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (avg_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (mismatch_cnt == 0 && avg_expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/csavg_pkg.sv
design/calibrated_sample_averager.sv
design/csavg_checker.sv
tb/sv/testbench.sv
